// File: rtl/fpk_pkg.sv
// Shared types, constants and the byte-wise CRC-16/MODBUS step for the frame packer.
// No dependencies.
package fpk_pkg;

  localparam int unsigned FrameBytes = 10;
  localparam int unsigned DataBytes  = 8;

  typedef logic [3:0] idx_t;

  localparam idx_t LastIdx   = idx_t'(FrameBytes - 1);
  localparam idx_t CrcLoIdx  = idx_t'(DataBytes);

  localparam logic [15:0] CrcSeed = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       is_last;
  } beat_t;

  // One data byte into the reflected CRC, eight bit steps.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] acc;
    acc = crc ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (acc[0]) begin
        acc = (acc >> 1) ^ CrcPoly;
      end else begin
        acc = acc >> 1;
      end
    end
    return acc;
  endfunction

endpackage

// File: rtl/fpk_out_reg.sv
// Output register for the frame packer: holds one beat until the receiver takes it.
// Depends on fpk_pkg.
module fpk_out_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  fpk_pkg::beat_t beat_in,
  output logic          can_load,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    frame_byte,
  output logic          is_last
);

  logic          valid;
  fpk_pkg::beat_t beat;

  // slot is free when empty or when its beat leaves this cycle
  assign can_load = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (out_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      beat <= beat_in;
    end
  end

  assign out_valid  = valid;
  assign frame_byte = beat.frame_byte;
  assign is_last    = beat.is_last;

endmodule

// File: rtl/four_channel_crc16_frame_packer_unit.sv
// Top level of the four-channel CRC-16 frame packer.
// Depends on fpk_pkg and fpk_out_reg.
//
// Input channel: one beat carries four 16-bit samples (chan_one .. chan_four),
// taken when in_valid and in_ready are both high.
// Output channel: ten byte beats per input beat. Bytes 1-8 are the samples,
// low byte first, in channel order; bytes 9-10 are the CRC-16/MODBUS of those
// eight bytes, low byte first. is_last is high on byte ten only.
//
// Path: the taken sample set is registered, then each byte passes the output register.
// Throughput: one byte per cycle while out_ready stays high, with no gap between frames;
// the next sample set is taken in the cycle the tenth byte moves to the output
// register. The CRC advances one byte with each byte loaded into the output register.
//
// Stall: a low out_ready holds the output register and the byte counter;
// in_ready stays low until the current frame's last byte is loaded.
// Reset (rst, synchronous): drops any frame in progress and empties the
// output register; no initialization is needed.
module four_channel_crc16_frame_packer_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] chan_one,
  input  logic signed [15:0] chan_two,
  input  logic signed [15:0] chan_three,
  input  logic signed [15:0] chan_four,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         frame_byte,
  output logic               is_last
);

  logic [63:0]         samples;
  logic                busy;
  fpk_pkg::idx_t       idx;
  logic [15:0]         crc;

  logic                can_load;
  logic                load;
  logic                in_fire;
  logic [7:0]          cur_byte;
  fpk_pkg::beat_t      beat_next;

  assign load     = busy && can_load;
  assign in_ready = !busy || (load && (idx == fpk_pkg::LastIdx));
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    case (idx)
      4'd0:    cur_byte = samples[7:0];
      4'd1:    cur_byte = samples[15:8];
      4'd2:    cur_byte = samples[23:16];
      4'd3:    cur_byte = samples[31:24];
      4'd4:    cur_byte = samples[39:32];
      4'd5:    cur_byte = samples[47:40];
      4'd6:    cur_byte = samples[55:48];
      4'd7:    cur_byte = samples[63:56];
      4'd8:    cur_byte = crc[7:0];
      4'd9:    cur_byte = crc[15:8];
      default: cur_byte = 8'h00;
    endcase
    beat_next.frame_byte = cur_byte;
    beat_next.is_last    = (idx == fpk_pkg::LastIdx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (in_fire) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (load) begin
      if (idx == fpk_pkg::LastIdx) begin
        busy <= 1'b0;
        idx  <= '0;
      end else begin
        idx <= idx + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      samples <= {chan_four, chan_three, chan_two, chan_one};
      crc     <= fpk_pkg::CrcSeed;
    end else if (load && (idx < fpk_pkg::CrcLoIdx)) begin
      crc <= fpk_pkg::crc_byte(crc, cur_byte);
    end
  end

  fpk_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .beat_in    (beat_next),
    .can_load   (can_load),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .frame_byte (frame_byte),
    .is_last    (is_last)
  );

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    !(busy && (idx > fpk_pkg::LastIdx)))
    else $error("byte index past end of frame");

  a_new_frame: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (busy && (idx == '0)))
    else $error("accepted sample set did not start a frame at byte one");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    load |=> (out_valid && (is_last == ($past(idx) == fpk_pkg::LastIdx))))
    else $error("last flag out of step with byte index");

endmodule
